// ----- sv/adam_gradient_moment_update_top_macros.svh -----
// ----------------------------------------------------------------------------
// adam gradient moment update assertion macros
// shared concurrent assertion forms, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef ADAM_GRADIENT_MOMENT_UPDATE_TOP_MACROS_SVH
`define ADAM_GRADIENT_MOMENT_UPDATE_TOP_MACROS_SVH
`ifndef SYNTHESIS
// implication into the next cycle
`define AGMU_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("agmu assertion failed");
// implication in the same cycle
`define AGMU_ASSERT_SAME(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("agmu assertion failed");
`else
`define AGMU_ASSERT_NEXT(name, clk, rst_n, pre, post)
`define AGMU_ASSERT_SAME(name, clk, rst_n, pre, post)
`endif
`endif

// ----- sv/agmu_pkg.sv -----
// ----------------------------------------------------------------------------
// agmu_pkg
// shared widths, reset values, datapath commands and status
// ----------------------------------------------------------------------------
package agmu_pkg;

    localparam int ENTRIES   = 1024;
    localparam int ADDR_W    = $clog2(ENTRIES);
    localparam int ENTRY_W   = 10;
    localparam int GRAD_W    = 32;
    localparam int MOM_W     = 48;
    localparam int BETA_W    = 16;
    localparam int POW_W     = 32;
    localparam int CFG_IDX_W = 2;

    // shared long divider
    localparam int NUM_W = 128;
    localparam int DEN_W = 64;
    localparam int CNT_W = 7;

    // square root unit
    localparam int ROOT_W = 56;
    localparam int SQX_W  = 2 * ROOT_W;

    localparam logic [BETA_W-1:0] BETA_ONE_RST = 16'd58982;
    localparam logic [BETA_W-1:0] BETA_TWO_RST = 16'd65470;
    localparam logic [BETA_W-1:0] STAB_RST     = 16'd43;

    localparam logic [CFG_IDX_W-1:0] CFG_BETA_ONE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA_TWO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STAB     = 2'd2;

    // quotient bits per division
    localparam logic [CNT_W-1:0] ITER_V = 7'd112;
    localparam logic [CNT_W-1:0] ITER_M = 7'd80;
    localparam logic [CNT_W-1:0] ITER_R = 7'd95;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLR,
        OP_MA,
        OP_MB,
        OP_SQ,
        OP_VA,
        OP_VB,
        OP_WR,
        OP_SQRT,
        OP_MDIV,
        OP_RDIV,
        OP_OUT
    } t_op;

    typedef struct packed {
        logic take;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic div_busy;
        logic sqrt_busy;
        logic den_zero;
        logic out_busy;
    } t_status;

endpackage

// ----- sv/agmu_in_if.sv -----
// ----------------------------------------------------------------------------
// agmu_in_if
// gradient beat channel
// ----------------------------------------------------------------------------
interface agmu_in_if import agmu_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic                     action;
    logic [ENTRY_W-1:0]       entry;
    logic signed [GRAD_W-1:0] gradient;
    logic                     end_of_step;

    modport source(output valid, action, entry, gradient, end_of_step, input ready);
    modport sink(input valid, action, entry, gradient, end_of_step, output ready);
endinterface

// ----- sv/agmu_out_if.sv -----
// ----------------------------------------------------------------------------
// agmu_out_if
// adjusted gradient beat channel
// ----------------------------------------------------------------------------
interface agmu_out_if import agmu_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [ENTRY_W-1:0]       entry_out;
    logic signed [GRAD_W-1:0] adjusted;
    logic                     saturated;

    modport source(output valid, entry_out, adjusted, saturated, input ready);
    modport sink(input valid, entry_out, adjusted, saturated, output ready);
endinterface

// ----- sv/agmu_div.sv -----
// ----------------------------------------------------------------------------
// agmu_div
// restoring long divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module agmu_div import agmu_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [CNT_W-1:0] i_iters,
    output logic             o_busy,
    output logic [NUM_W-1:0] o_quot
);

    logic [NUM_W-1:0] r_n;
    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_d;
    logic [DEN_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             ge;

    // numerator is left aligned, msb enters first
    assign shifted = {r_rem, r_n[NUM_W-1]};
    assign ge      = shifted >= {1'b0, r_d};
    assign diff    = shifted - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_iters;
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= r_cnt != CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_num;
            r_d   <= i_den;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            r_n   <= {r_n[NUM_W-2:0], 1'b0};
            r_rem <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            r_q   <= {r_q[NUM_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;

endmodule

// ----- sv/agmu_sqrt.sv -----
// ----------------------------------------------------------------------------
// agmu_sqrt
// digit by digit integer square root, one root bit per cycle
// ----------------------------------------------------------------------------
module agmu_sqrt import agmu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SQX_W-1:0]  i_x,
    output logic              o_busy,
    output logic [ROOT_W-1:0] o_root
);

    localparam int SC_W = $clog2(ROOT_W + 1);

    logic [SQX_W-1:0]  r_x;
    logic [ROOT_W+1:0] r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [SC_W-1:0]   r_cnt;
    logic              r_busy;
    logic [ROOT_W+3:0] shifted;
    logic [ROOT_W+3:0] trial;
    logic [ROOT_W+3:0] diff;
    logic              ge;

    assign shifted = {r_rem, r_x[SQX_W-1 -: 2]};
    assign trial   = {2'b00, r_root, 2'b01};
    assign ge      = shifted >= trial;
    assign diff    = shifted - trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= SC_W'(ROOT_W);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= r_cnt != SC_W'(1);
        end
    end

    // remainder never exceeds twice the root, so the top bits drop safely
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_x;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x    <= {r_x[SQX_W-3:0], 2'b00};
            r_rem  <= ge ? diff[ROOT_W+1:0] : shifted[ROOT_W+1:0];
            r_root <= {r_root[ROOT_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

// ----- sv/agmu_ctrl.sv -----
// ----------------------------------------------------------------------------
// agmu_ctrl
// sequencer for moment update, divisions, square root, clearing and output
// ----------------------------------------------------------------------------
module agmu_ctrl import agmu_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_action,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_MA,
        S_MB,
        S_SQ,
        S_VA,
        S_VB,
        S_WR,
        S_VWAIT,
        S_SWAIT,
        S_MWAIT,
        S_RWAIT,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    t_op    op;
    logic   take;

    assign o_in_ready = r_state == S_IDLE;
    assign take       = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        op      = OP_NONE;
        case (r_state)
            S_CLR: begin
                op = OP_CLR;
                if (i_status.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (take) n_state = i_action ? S_CLR : S_MA;
            end
            S_MA: begin
                op      = OP_MA;
                n_state = S_MB;
            end
            S_MB: begin
                op      = OP_MB;
                n_state = S_SQ;
            end
            S_SQ: begin
                op      = OP_SQ;
                n_state = S_VA;
            end
            S_VA: begin
                op      = OP_VA;
                n_state = S_VB;
            end
            S_VB: begin
                op      = OP_VB;
                n_state = S_WR;
            end
            S_WR: begin
                op      = OP_WR;
                n_state = S_VWAIT;
            end
            S_VWAIT: begin
                if (!i_status.div_busy) begin
                    op      = OP_SQRT;
                    n_state = S_SWAIT;
                end
            end
            S_SWAIT: begin
                if (!i_status.sqrt_busy) begin
                    op      = OP_MDIV;
                    n_state = S_MWAIT;
                end
            end
            S_MWAIT: begin
                if (!i_status.div_busy) begin
                    op      = OP_RDIV;
                    n_state = i_status.den_zero ? S_OUT : S_RWAIT;
                end
            end
            S_RWAIT: begin
                if (!i_status.div_busy) n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_status.out_busy) begin
                    op      = OP_OUT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.take = take;
    assign o_cmd.op   = op;

endmodule

// ----- sv/agmu_dp.sv -----
// ----------------------------------------------------------------------------
// agmu_dp
// moment store, scaling multiplier, divider, square root and result register
// ----------------------------------------------------------------------------
module agmu_dp import agmu_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_status                  o_status,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [BETA_W-1:0]        i_cfg_data,
    input  logic                     i_action,
    input  logic [ENTRY_W-1:0]       i_entry,
    input  logic signed [GRAD_W-1:0] i_gradient,
    input  logic                     i_end_of_step,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output logic [ENTRY_W-1:0]       o_entry_out,
    output logic signed [GRAD_W-1:0] o_adjusted,
    output logic                     o_saturated
);

    localparam int WORD_W = 2 * MOM_W;
    localparam int MAG_W  = MOM_W + 1;
    localparam int K_W    = BETA_W + 1;
    localparam int PROD_W = MAG_W + K_W;
    localparam int RND_W  = PROD_W - BETA_W;
    localparam int SUM_W  = MOM_W + 3;
    localparam int D_W    = POW_W + 1;
    localparam int MH_W   = 63;
    localparam int DENR_W = ROOT_W + 1;

    logic [WORD_W-1:0] mem [ENTRIES];

    logic [BETA_W-1:0]        r_b1;
    logic [BETA_W-1:0]        r_b2;
    logic [BETA_W-1:0]        r_stab;
    logic [POW_W-1:0]         r_p1;
    logic [POW_W-1:0]         r_p2;
    logic [ADDR_W-1:0]        r_clr_cnt;
    logic [ENTRY_W-1:0]       r_entry;
    logic signed [GRAD_W-1:0] r_g;
    logic                     r_eos;
    logic [WORD_W-1:0]        r_rd;
    logic signed [SUM_W-1:0]  r_ma;
    logic [MOM_W-1:0]         r_m;
    logic [MOM_W-1:0]         r_sq;
    logic [RND_W-1:0]         r_va;
    logic [MOM_W-1:0]         r_v;
    logic                     r_mneg;
    logic [MOM_W-1:0]         r_mmag;
    logic [MH_W-1:0]          r_mhat;
    logic                     r_dz;
    logic                     r_out_valid;
    logic [ENTRY_W-1:0]       r_out_entry;
    logic [GRAD_W-1:0]        r_out_adj;
    logic                     r_out_sat;

    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_wa;
    logic [WORD_W-1:0]       mem_wd;
    logic                    gneg;
    logic [GRAD_W-1:0]       gmag;
    logic                    mold_neg;
    logic [MOM_W-1:0]        mold_mag;
    logic [MAG_W-1:0]        mul_a;
    logic [K_W-1:0]          mul_k;
    logic [PROD_W-1:0]       prod;
    logic [RND_W-1:0]        rnd;
    logic signed [SUM_W-1:0] term;
    logic signed [SUM_W-1:0] msum;
    logic [SUM_W-1:0]        vsum;
    logic [2*GRAD_W-1:0]     sqp;
    logic [D_W-1:0]          d1;
    logic [D_W-1:0]          d2;
    logic                    div_start;
    logic [NUM_W-1:0]        div_num;
    logic [DEN_W-1:0]        div_den;
    logic [CNT_W-1:0]        div_iters;
    logic                    div_busy;
    logic [NUM_W-1:0]        div_q;
    logic                    sqrt_busy;
    logic [ROOT_W-1:0]       root;
    logic [DENR_W-1:0]       den_r;
    logic [MH_W-1:0]         mhat;
    logic [GRAD_W-1:0]       limit;
    logic [GRAD_W-1:0]       res;
    logic                    sat;
    logic [2*POW_W-1:0]      pw1;
    logic [2*POW_W-1:0]      pw2;

    // operand preparation
    assign gneg     = r_g[GRAD_W-1];
    assign gmag     = gneg ? GRAD_W'(-r_g) : GRAD_W'(r_g);
    assign mold_neg = r_rd[WORD_W-1];
    assign mold_mag = mold_neg ? MOM_W'(-r_rd[WORD_W-1:MOM_W]) : r_rd[WORD_W-1:MOM_W];

    // shared scaling multiplier, rounded half away on magnitudes
    always_comb begin
        case (i_cmd.op)
            OP_MA: begin
                mul_a = MAG_W'(mold_mag);
                mul_k = K_W'(r_b1);
            end
            OP_MB: begin
                mul_a = MAG_W'(gmag);
                mul_k = K_W'(17'h10000 - K_W'(r_b1));
            end
            OP_VA: begin
                mul_a = MAG_W'(r_rd[MOM_W-1:0]);
                mul_k = K_W'(r_b2);
            end
            OP_VB: begin
                mul_a = MAG_W'(r_sq);
                mul_k = K_W'(17'h10000 - K_W'(r_b2));
            end
            default: begin
                mul_a = '0;
                mul_k = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_k;
    assign rnd  = RND_W'((prod + PROD_W'(16'h8000)) >> BETA_W);
    assign term = $signed(SUM_W'(rnd));
    assign msum = r_ma + (gneg ? -term : term);
    assign vsum = SUM_W'(r_va) + SUM_W'(rnd);
    assign sqp  = gmag * gmag;

    assign d1 = {1'b1, {POW_W{1'b0}}} - {1'b0, r_p1};
    assign d2 = {1'b1, {POW_W{1'b0}}} - {1'b0, r_p2};

    assign den_r = {1'b0, root} + DENR_W'(r_stab);
    assign mhat  = (div_q[79:MH_W] != '0) ? {MH_W{1'b1}} : div_q[MH_W-1:0];

    // divider operand select
    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        div_iters = '0;
        case (i_cmd.op)
            OP_WR: begin
                div_start = 1'b1;
                div_num   = {r_v, {(NUM_W-MOM_W){1'b0}}};
                div_den   = DEN_W'(d2);
                div_iters = ITER_V;
            end
            OP_MDIV: begin
                div_start = 1'b1;
                div_num   = {r_mmag, {(NUM_W-MOM_W){1'b0}}};
                div_den   = DEN_W'(d1);
                div_iters = ITER_M;
            end
            OP_RDIV: begin
                div_start = 1'b1;
                div_num   = {mhat, {(NUM_W-MH_W){1'b0}}};
                div_den   = DEN_W'(den_r);
                div_iters = ITER_R;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    agmu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_iters (div_iters),
        .o_busy  (div_busy),
        .o_quot  (div_q)
    );

    agmu_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_SQRT),
        .i_x     (div_q[SQX_W-1:0]),
        .o_busy  (sqrt_busy),
        .o_root  (root)
    );

    // final quotient check against the signed range
    always_comb begin
        limit = r_mneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        if (r_dz) begin
            sat = r_mhat != '0;
            res = sat ? limit : '0;
        end else if (div_q[94:GRAD_W] != '0 || div_q[GRAD_W-1:0] > limit) begin
            sat = 1'b1;
            res = limit;
        end else begin
            sat = 1'b0;
            res = div_q[GRAD_W-1:0];
        end
    end

    assign pw1 = 64'(r_p1) * 64'(r_b1);
    assign pw2 = 64'(r_p2) * 64'(r_b2);

    // moment store: clearing sweep or one write per update
    assign mem_we = i_cmd.op == OP_CLR || i_cmd.op == OP_WR;
    assign mem_wa = (i_cmd.op == OP_CLR) ? r_clr_cnt : r_entry[ADDR_W-1:0];
    assign mem_wd = (i_cmd.op == OP_CLR) ? '0 : {r_m, r_v};

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        if (i_cmd.take) r_rd <= mem[i_entry[ADDR_W-1:0]];
    end

    // configuration, powers, sweep counter and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1        <= BETA_ONE_RST;
            r_b2        <= BETA_TWO_RST;
            r_stab      <= STAB_RST;
            r_p1        <= {BETA_ONE_RST, 16'h0000};
            r_p2        <= {BETA_TWO_RST, 16'h0000};
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BETA_ONE: r_b1   <= i_cfg_data;
                    CFG_BETA_TWO: r_b2   <= i_cfg_data;
                    CFG_STAB:     r_stab <= i_cfg_data;
                    default:      r_stab <= r_stab;
                endcase
            end
            if (i_cmd.take && i_action) begin
                r_p1      <= {r_b1, 16'h0000};
                r_p2      <= {r_b2, 16'h0000};
                r_clr_cnt <= '0;
            end
            if (i_cmd.op == OP_CLR) r_clr_cnt <= r_clr_cnt + 1'b1;
            if (i_cmd.op == OP_OUT) begin
                r_out_valid <= 1'b1;
                if (r_eos) begin
                    r_p1 <= pw1[47:16];
                    r_p2 <= pw2[47:16];
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_entry <= i_entry;
            r_g     <= i_gradient;
            r_eos   <= i_end_of_step;
        end
        case (i_cmd.op)
            OP_MA: r_ma <= mold_neg ? -$signed(SUM_W'(rnd)) : $signed(SUM_W'(rnd));
            OP_MB: begin
                if (msum[SUM_W-1:MOM_W-1] != '0 && msum[SUM_W-1:MOM_W-1] != '1) begin
                    r_m <= msum[SUM_W-1] ? {1'b1, {(MOM_W-1){1'b0}}}
                                         : {1'b0, {(MOM_W-1){1'b1}}};
                end else begin
                    r_m <= msum[MOM_W-1:0];
                end
            end
            OP_SQ: r_sq <= sqp[2*GRAD_W-1:BETA_W];
            OP_VA: r_va <= rnd;
            OP_VB: r_v  <= (vsum[SUM_W-1:MOM_W] != '0) ? '1 : vsum[MOM_W-1:0];
            OP_WR: begin
                r_mneg <= r_m[MOM_W-1];
                r_mmag <= r_m[MOM_W-1] ? MOM_W'(-r_m) : r_m;
            end
            OP_RDIV: begin
                r_mhat <= mhat;
                r_dz   <= den_r == '0;
            end
            OP_OUT: begin
                r_out_entry <= r_entry;
                r_out_adj   <= r_mneg ? GRAD_W'(-res) : res;
                r_out_sat   <= sat;
            end
            default: r_dz <= r_dz;
        endcase
    end

    assign o_status.clr_last  = r_clr_cnt == ADDR_W'(ENTRIES - 1);
    assign o_status.div_busy  = div_busy;
    assign o_status.sqrt_busy = sqrt_busy;
    assign o_status.den_zero  = den_r == '0;
    assign o_status.out_busy  = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_entry_out = r_out_entry;
    assign o_adjusted  = $signed(r_out_adj);
    assign o_saturated = r_out_sat;

endmodule

// ----- sv/adam_gradient_moment_update_top.sv -----
// ----------------------------------------------------------------------------
// adam gradient moment update
// adam moment refresh and bias-corrected gradient scaling per element
//
//   port       dir   beat contents
//   i_grad     in    action, entry, gradient, end_of_step
//   o_res      out   entry_out, adjusted, saturated
//   i_cfg_*    in    beta_one, beta_two, stabilizer writes
//
// an update runs six moment update steps, then the shared one-bit-per-cycle
// divider (112 bits), 56 square root steps, then 80 and maybe 95 more bits
// a restart sweeps the moment store, clearing one entry a cycle
// the same sweep runs after reset before the first beat is taken
// a held result does not stop the next beat; the block waits only at its end
// ----------------------------------------------------------------------------
`include "adam_gradient_moment_update_top_macros.svh"

module adam_gradient_moment_update_top import agmu_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    agmu_in_if.sink              i_grad,
    agmu_out_if.source           o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BETA_W-1:0]    i_cfg_data
);

    t_cmd    cmd;
    t_status status;
    logic    in_ready;

    agmu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_grad.valid),
        .i_action   (i_grad.action),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    agmu_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_action      (i_grad.action),
        .i_entry       (i_grad.entry),
        .i_gradient    (i_grad.gradient),
        .i_end_of_step (i_grad.end_of_step),
        .i_out_ready   (o_res.ready),
        .o_out_valid   (o_res.valid),
        .o_entry_out   (o_res.entry_out),
        .o_adjusted    (o_res.adjusted),
        .o_saturated   (o_res.saturated)
    );

    assign i_grad.ready = in_ready;

    // every accepted beat leaves ready low in the cycle after it is taken
    `AGMU_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_grad.valid && i_grad.ready, !i_grad.ready)
    // a new result only appears as the sequencer leaves its busy states
    `AGMU_ASSERT_SAME(a_result_after_busy, i_clk, i_rst_n, $rose(o_res.valid), !$past(i_grad.ready))

endmodule
